[src/bfpe_pkg.sv]
// ----------------------------------------------------------------------------
// bfpe_pkg: shared types and constants of the tape-machine program executor
// Memory depths, derived widths, instruction codes, item commands, result kinds,
// sequencer states and the outcome of one executed instruction.
// ----------------------------------------------------------------------------
package bfpe_pkg;

  // Memory depths and the widths that follow from them
  localparam int PROGRAM_DEPTH = 4096;
  localparam int TAPE_DEPTH    = 32768;
  localparam int PROG_AW       = $clog2(PROGRAM_DEPTH);
  localparam int PROG_CW       = $clog2(PROGRAM_DEPTH + 1);
  localparam int TAPE_AW       = $clog2(TAPE_DEPTH);

  // Instruction characters
  localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
  localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] OP_PUT   = 8'h2E;  // '.'
  localparam logic [7:0] OP_DUMP  = 8'h40;  // '@'
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_DUMP  = 2'd1,
    KIND_HALT  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_LINK,
    S_EXEC
  } state_t;

  // Outcome of one executed instruction
  typedef struct packed {
    logic [TAPE_AW-1:0] ptr_next;
    logic [PROG_CW-1:0] pc_next;
    logic               cell_we;
    logic [7:0]         cell_next;
    logic               emit;
    kind_t              kind;
  } exec_t;

endpackage

[src/bfpe_exec.sv]
// ----------------------------------------------------------------------------
// bfpe_exec: instruction decode and update unit
// Given the fetched instruction, the current cell, pointer, program counter
// and jump target, works out the next pointer, counter, cell and result.
// ----------------------------------------------------------------------------
module bfpe_exec (
  input  logic [7:0]                  op,
  input  logic [7:0]                  cell_val,
  input  logic [bfpe_pkg::TAPE_AW-1:0] ptr,
  input  logic [bfpe_pkg::PROG_CW-1:0] pc,
  input  logic [bfpe_pkg::PROG_AW-1:0] jump,
  output bfpe_pkg::exec_t             res
);
  import bfpe_pkg::*;

  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);
  localparam logic [TAPE_AW:0]   TAPE_END  = (TAPE_AW + 1)'(TAPE_DEPTH);

  logic [TAPE_AW:0]   ptr_inc;
  logic [PROG_CW-1:0] pc_inc;
  logic [PROG_CW-1:0] pc_jump;
  logic               cell_zero;

  // Incremented values and wrap checks
  assign ptr_inc   = {1'b0, ptr} + (TAPE_AW + 1)'(1);
  assign pc_inc    = pc + PROG_CW'(1);
  assign pc_jump   = {1'b0, jump} + PROG_CW'(1);
  assign cell_zero = (cell_val == 8'd0);

  // Decode
  always_comb begin
    res           = '0;
    res.ptr_next  = ptr;
    res.pc_next   = pc_inc;
    res.cell_next = cell_val;
    res.kind      = KIND_CHAR;
    case (op)
      OP_RIGHT: res.ptr_next = (ptr_inc >= TAPE_END) ? '0 : ptr_inc[TAPE_AW-1:0];
      OP_LEFT:  res.ptr_next = (ptr == '0) ? TAPE_LAST : ptr - TAPE_AW'(1);
      OP_INC: begin
        res.cell_we   = 1'b1;
        res.cell_next = cell_val + 8'd1;
      end
      OP_DEC: begin
        res.cell_we   = 1'b1;
        res.cell_next = cell_val - 8'd1;
      end
      OP_PUT: begin
        res.emit = 1'b1;
        res.kind = KIND_CHAR;
      end
      OP_DUMP: begin
        res.emit = 1'b1;
        res.kind = KIND_DUMP;
      end
      OP_OPEN: begin
        if (cell_zero) res.pc_next = pc_jump;
      end
      OP_CLOSE: begin
        if (!cell_zero) res.pc_next = pc_jump;
      end
      default: ;
    endcase
  end

endmodule

[src/bf_program_executor.sv]
// ----------------------------------------------------------------------------
// bf_program_executor: tape-machine program executor
// Loads program bytes, pairs brackets into a jump table and runs at most one
// instruction per step word.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load word leaves the
// block idle, except a ']' that closes a bracket, which passes through S_POP
// and S_LINK: the jump table has one write port, so both directions of the
// pair are written in turn after the partner is popped off the bracket stack.
// A step word that runs an instruction fetches from the program and tape
// memories, then executes in S_EXEC and writes the cell back; a step that
// reports a halt or a bracket error leaves the block idle. Results come out
// in the cycle after the word finishes, on out_kind and out_value for exactly
// one cycle with strobe high; the receiver cannot stall them. After reset the
// tape is cleared one cell a cycle, and busy stays high until it is all clear.
module bf_program_executor (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cmd,
  input  logic [7:0] prog_byte,
  output logic       strobe,
  output logic [1:0] out_kind,
  output logic [7:0] out_value
);
  import bfpe_pkg::*;

  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);
  localparam logic [PROG_CW-1:0] PROG_FULL = PROG_CW'(PROGRAM_DEPTH);

  // Memories
  logic [7:0]         program_store [PROGRAM_DEPTH];
  logic [PROG_AW-1:0] jump_table    [PROGRAM_DEPTH];
  logic [PROG_AW-1:0] bracket_stack [PROGRAM_DEPTH];
  logic [7:0]         tape_cells    [TAPE_DEPTH];

  // Control registers
  state_t             state, state_next;
  logic [PROG_CW-1:0] pc;
  logic [PROG_CW-1:0] length;
  logic [PROG_CW-1:0] depth;
  logic [TAPE_AW-1:0] ptr;
  logic [TAPE_AW-1:0] clr_addr;
  logic               err;
  logic [PROG_AW-1:0] pos;
  logic [PROG_AW-1:0] open_pos;

  // Registered read data
  logic [7:0]         op_rd;
  logic [7:0]         cell_rd;
  logic [PROG_AW-1:0] jmp_rd;
  logic [PROG_AW-1:0] stk_rd;

  // Result registers
  kind_t              kind;
  logic [7:0]         value;

  // Decoded control
  logic               accept;
  logic               is_load;
  logic               not_full;
  logic               byte_open;
  logic               byte_close;
  logic               step_fault;
  logic               step_halt;
  logic [PROG_CW-1:0] depth_dec;
  logic               prog_we;
  logic               stk_we;
  logic               jt_we;
  logic [PROG_AW-1:0] jt_waddr;
  logic [PROG_AW-1:0] jt_wdata;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [7:0]         tape_wdata;
  exec_t              ex;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign is_load    = (cmd == CMD_LOAD);
  assign not_full   = (length != PROG_FULL);
  assign byte_open  = (prog_byte == OP_OPEN);
  assign byte_close = (prog_byte == OP_CLOSE);
  assign step_fault = err || (depth != '0);
  assign step_halt  = (pc >= length);
  assign depth_dec  = depth - PROG_CW'(1);

  // Instruction unit
  bfpe_exec u_exec (
    .op       (op_rd),
    .cell_val (cell_rd),
    .ptr      (ptr),
    .pc       (pc),
    .jump     (jmp_rd),
    .res      (ex)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == TAPE_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (is_load) begin
            if (not_full && byte_close && depth != '0) state_next = S_POP;
          end else if (!step_fault && !step_halt) begin
            state_next = S_EXEC;
          end
        end
      end
      S_POP:  state_next = S_LINK;
      S_LINK: state_next = S_IDLE;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory write controls
  always_comb begin
    prog_we    = 1'b0;
    stk_we     = 1'b0;
    jt_we      = 1'b0;
    jt_waddr   = pos;
    jt_wdata   = open_pos;
    tape_we    = 1'b0;
    tape_waddr = ptr;
    tape_wdata = ex.cell_next;
    case (state)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_addr;
        tape_wdata = 8'd0;
      end
      S_IDLE: begin
        prog_we = accept && is_load && not_full;
        stk_we  = accept && is_load && not_full && byte_open;
      end
      S_POP: begin
        jt_we    = 1'b1;
        jt_waddr = stk_rd;
        jt_wdata = pos;
      end
      S_LINK: jt_we = 1'b1;
      S_EXEC: tape_we = ex.cell_we;
      default: ;
    endcase
  end

  // Program store: written at the load position, read at the counter
  always_ff @(posedge clk) begin
    if (prog_we) program_store[length[PROG_AW-1:0]] <= prog_byte;
    op_rd <= program_store[pc[PROG_AW-1:0]];
  end

  // Bracket stack: pushed at depth, top read at depth minus one
  always_ff @(posedge clk) begin
    if (stk_we) bracket_stack[depth[PROG_AW-1:0]] <= length[PROG_AW-1:0];
    stk_rd <= bracket_stack[depth_dec[PROG_AW-1:0]];
  end

  // Jump table
  always_ff @(posedge clk) begin
    if (jt_we) jump_table[jt_waddr] <= jt_wdata;
    jmp_rd <= jump_table[pc[PROG_AW-1:0]];
  end

  // Tape
  always_ff @(posedge clk) begin
    if (tape_we) tape_cells[tape_waddr] <= tape_wdata;
    cell_rd <= tape_cells[ptr];
  end

  // Sequencer and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      pc       <= '0;
      length   <= '0;
      depth    <= '0;
      ptr      <= '0;
      clr_addr <= '0;
      err      <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + TAPE_AW'(1);
        S_IDLE: begin
          if (accept && is_load && not_full) begin
            length <= length + PROG_CW'(1);
            if (byte_open) begin
              depth <= depth + PROG_CW'(1);
            end else if (byte_close) begin
              if (depth == '0) err <= 1'b1;
              else depth <= depth_dec;
            end
          end
          if (accept && !is_load && (step_fault || step_halt)) strobe <= 1'b1;
        end
        S_EXEC: begin
          pc     <= ex.pc_next;
          ptr    <= ex.ptr_next;
          strobe <= ex.emit;
        end
        default: ;
      endcase
    end
  end

  // Load position, popped partner and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pos <= length[PROG_AW-1:0];
        if (step_fault) begin
          kind  <= KIND_ERROR;
          value <= 8'd0;
        end else begin
          kind  <= KIND_HALT;
          value <= 8'd0;
        end
      end
      S_POP: open_pos <= stk_rd;
      S_EXEC: begin
        kind  <= ex.kind;
        value <= cell_rd;
      end
      default: ;
    endcase
  end

  assign out_kind  = kind;
  assign out_value = value;

endmodule

[src/bfpe_checker.sv]
// ----------------------------------------------------------------------------
// bfpe_checker: port-level checks for the program executor
// Watches the handshake and result ports of the top level over time.
// ----------------------------------------------------------------------------
module bfpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       cmd,
  input logic       strobe,
  input logic [1:0] out_kind,
  input logic [7:0] out_value
);
  import bfpe_pkg::*;

  // Halt and error words carry a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    strobe && (out_kind == KIND_HALT || out_kind == KIND_ERROR) |-> out_value == 8'd0)
    else $error("halt or error result with nonzero value");

  // A result only follows an accepted word or work in progress
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy || start))
    else $error("result strobe without a word behind it");

  // The block is ready again while a result is shown
  a_ready_on_result: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("busy while a result is shown");

  // The tape clear keeps the block busy right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy && !strobe)
    else $error("block ready straight after reset");

  // Load words never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_LOAD |=> !strobe)
    else $error("result after a load word");

endmodule

bind bf_program_executor bfpe_checker u_bfpe_checker (.*);

[test/tb_bf_program_executor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bf_program_executor: self-checking bench for the tape-machine executor
// Loads programs and single-steps them through the start/busy port. A
// built-in model of the executor predicts every strobed result, and a
// monitor compares each one with the oldest prediction. The run opens with
// a short hand-written program, then loads random terminating fragments and
// steps them to the end. Last, it closes on an unmatched bracket.
// ----------------------------------------------------------------------------
module tb_bf_program_executor;
  import bfpe_pkg::*;

  localparam int RANDOM_WORDS   = 1700;
  localparam int TIMEOUT_CYCLES = 1500000;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } word_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] value;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       cmd = CMD_LOAD;
  logic [7:0] prog_byte = 8'h00;
  logic       busy;
  logic       strobe;
  logic [1:0] out_kind;
  logic [7:0] out_value;

  // Words waiting for the driver, results waiting for the monitor
  word_t   pending_words[$];
  result_t expected_out[$];

  // Executor state as the model sees it
  bit [7:0]         prog_mem [PROGRAM_DEPTH];
  bit [PROG_AW-1:0] jump_mem [PROGRAM_DEPTH];
  bit [PROG_AW-1:0] open_stack [PROGRAM_DEPTH];
  bit [7:0]         tape_mem [TAPE_DEPTH];
  int               open_depth = 0;
  int               prog_len = 0;
  int               exec_pc = 0;
  int               tape_ptr = 0;
  bit               close_err = 1'b0;

  // Stimulus planning: where the tape will stand once queued steps have run
  logic [7:0] plan_tape [int];
  int         plan_ptr = 0;
  int         plan_len = 0;
  logic [7:0] frag_bytes[$];

  int      burst_left = 0;
  int      gap_left = 0;
  int      words_issued = 0;
  int      words_taken = 0;
  int      steps_taken = 0;
  int      fail_count = 0;
  int      kind_seen [4];
  word_t   drive_word;
  result_t want;

  bf_program_executor u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .prog_byte (prog_byte),
    .strobe    (strobe),
    .out_kind  (out_kind),
    .out_value (out_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model: apply one accepted word, queue the result it causes
  function automatic void execute_word(logic word_cmd, logic [7:0] word_data);
    result_t    res;
    bit         emit_res;
    int         here;
    bit [7:0]   op;
    bit [7:0]   val;
    bit [PROG_AW-1:0] opened;
    emit_res = 1'b0;
    if (word_cmd == CMD_LOAD) begin
      // loads past a full program are dropped, brackets included
      if (prog_len < PROGRAM_DEPTH) begin
        here = prog_len;
        prog_mem[here] = word_data;
        prog_len = here + 1;
        if (word_data == OP_OPEN) begin
          open_stack[open_depth] = PROG_AW'(here);
          open_depth++;
        end else if (word_data == OP_CLOSE) begin
          if (open_depth == 0) begin
            close_err = 1'b1;
          end else begin
            open_depth--;
            opened = open_stack[open_depth];
            jump_mem[opened] = PROG_AW'(here);
            jump_mem[here] = opened;
          end
        end
      end
    end else if (close_err || open_depth != 0) begin
      res.kind = KIND_ERROR;
      res.value = 8'h00;
      emit_res = 1'b1;
    end else if (exec_pc >= prog_len) begin
      res.kind = KIND_HALT;
      res.value = 8'h00;
      emit_res = 1'b1;
    end else begin
      here = exec_pc;
      op = prog_mem[here];
      val = tape_mem[tape_ptr];
      exec_pc = here + 1;
      case (op)
        OP_RIGHT: tape_ptr = (tape_ptr == TAPE_DEPTH - 1) ? 0 : tape_ptr + 1;
        OP_LEFT:  tape_ptr = (tape_ptr == 0) ? TAPE_DEPTH - 1 : tape_ptr - 1;
        OP_INC:   tape_mem[tape_ptr] = val + 8'd1;
        OP_DEC:   tape_mem[tape_ptr] = val - 8'd1;
        OP_PUT: begin
          res.kind = KIND_CHAR;
          res.value = val;
          emit_res = 1'b1;
        end
        OP_DUMP: begin
          res.kind = KIND_DUMP;
          res.value = val;
          emit_res = 1'b1;
        end
        OP_OPEN:  if (val == 8'h00) exec_pc = int'(jump_mem[here]) + 1;
        OP_CLOSE: if (val != 8'h00) exec_pc = int'(jump_mem[here]) + 1;
        default: ;
      endcase
    end
    if (emit_res) expected_out.push_back(res);
  endfunction

  function automatic void queue_word(logic word_cmd, logic [7:0] word_data);
    word_t w;
    w.cmd = word_cmd;
    w.data = word_data;
    pending_words.push_back(w);
    words_issued++;
  endfunction

  function automatic logic [7:0] plan_val(int p);
    return plan_tape.exists(p) ? plan_tape[p] : tape_mem[p];
  endfunction

  function automatic void plan_apply(logic [7:0] b);
    case (b)
      OP_RIGHT: plan_ptr = (plan_ptr + 1) % TAPE_DEPTH;
      OP_LEFT:  plan_ptr = (plan_ptr + TAPE_DEPTH - 1) % TAPE_DEPTH;
      OP_INC:   plan_tape[plan_ptr] = plan_val(plan_ptr) + 8'd1;
      OP_DEC:   plan_tape[plan_ptr] = plan_val(plan_ptr) - 8'd1;
      default: ;
    endcase
  endfunction

  // Any byte but a bracket; mostly instructions, the rest raw noise
  function automatic logic [7:0] pick_plain(bit allow_move);
    logic [7:0] ops [6];
    logic [7:0] b;
    ops = '{OP_RIGHT, OP_LEFT, OP_INC, OP_DEC, OP_PUT, OP_DUMP};
    if ($urandom_range(0, 4) < 3) b = ops[$urandom_range(allow_move ? 0 : 2, 5)];
    else b = 8'($urandom);
    while (b == OP_OPEN || b == OP_CLOSE ||
           (!allow_move && (b == OP_RIGHT || b == OP_LEFT)))
      b = 8'($urandom);
    return b;
  endfunction

  // Build one program fragment that always terminates; n_exec is the
  // number of step words it takes to run it to its end.
  task automatic plan_fragment(output int n_exec);
    int         here;
    int         far;
    int         v;
    int         k;
    int         m;
    int         d;
    int         depth;
    int         r;
    logic [7:0] b;
    n_exec = 0;
    frag_bytes.delete();
    repeat ($urandom_range(1, 8)) begin
      here = plan_ptr;
      v = plan_val(here);
      if ($urandom_range(0, 2) == 0 && v <= 4) begin
        frag_bytes.push_back(OP_OPEN);
        if (v == 0) begin
          // skipped loop: any well-formed body, nested brackets too
          depth = 0;
          repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(0, 3);
            if (r == 0 && depth < 3) begin
              frag_bytes.push_back(OP_OPEN);
              depth++;
            end else if (r == 1 && depth > 0) begin
              frag_bytes.push_back(OP_CLOSE);
              depth--;
            end else begin
              frag_bytes.push_back(pick_plain(1'b1));
            end
          end
          repeat (depth) frag_bytes.push_back(OP_CLOSE);
          n_exec += 1;
        end else begin
          // counted loop: decrement home cell, visit a cell k to the right
          k = $urandom_range(1, 3);
          m = $urandom_range(0, 4);
          d = 0;
          frag_bytes.push_back(OP_DEC);
          repeat (k) frag_bytes.push_back(OP_RIGHT);
          repeat (m) begin
            b = pick_plain(1'b0);
            frag_bytes.push_back(b);
            if (b == OP_INC) d++;
            else if (b == OP_DEC) d--;
          end
          repeat (k) frag_bytes.push_back(OP_LEFT);
          far = (here + k) % TAPE_DEPTH;
          plan_tape[here] = 8'h00;
          plan_tape[far] = 8'(plan_val(far) + v * d);
          n_exec += 1 + v * (2 * k + m + 2);
        end
        frag_bytes.push_back(OP_CLOSE);
      end else begin
        b = pick_plain(1'b1);
        frag_bytes.push_back(b);
        plan_apply(b);
        n_exec += 1;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || start || expected_out.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: bursts of words from the queue with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        execute_word(cmd, prog_byte);
        words_taken++;
        if (cmd == CMD_STEP) steps_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          drive_word = pending_words.pop_front();
          start <= 1'b1;
          cmd <= drive_word.cmd;
          prog_byte <= drive_word.data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 3);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe === 1'b1) begin
        if (expected_out.size() == 0) begin
          $error("result: none expected, got kind %0d value %0d", out_kind, out_value);
          fail_count++;
        end else begin
          want = expected_out.pop_front();
          kind_seen[int'(want.kind)]++;
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, out_value);
            fail_count++;
          end
        end
      end else if (strobe !== 1'b0) begin
        $error("strobe: expected 0 or 1, got %b", strobe);
        fail_count++;
      end
    end
  end

  initial begin : stimulus
    int n_exec;
    int open_now;
    int rand_base;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: halt on an empty program, both pointer wraps, cell wrap
    // both ways, noise bytes 00 and ff, error while a '[' is open, and a
    // loop skipped because its cell is zero.
    queue_word(CMD_STEP, 8'h00);
    queue_word(CMD_LOAD, OP_LEFT);
    queue_word(CMD_LOAD, OP_INC);
    queue_word(CMD_LOAD, OP_DUMP);
    queue_word(CMD_LOAD, OP_RIGHT);
    queue_word(CMD_LOAD, OP_DEC);
    queue_word(CMD_LOAD, OP_PUT);
    queue_word(CMD_LOAD, 8'h00);
    queue_word(CMD_LOAD, 8'hFF);
    queue_word(CMD_LOAD, OP_INC);
    queue_word(CMD_LOAD, OP_OPEN);
    queue_word(CMD_STEP, 8'hFF);
    queue_word(CMD_LOAD, OP_CLOSE);
    repeat (12) queue_word(CMD_STEP, 8'($urandom));
    wait_idle();

    // Random: terminating fragments, each stepped to its end and a little
    // past it, with steps slipped in while a bracket is still open
    plan_ptr = tape_ptr;
    plan_len = prog_len;
    rand_base = words_issued;
    while (words_issued - rand_base < RANDOM_WORDS && plan_len < 3600) begin
      plan_fragment(n_exec);
      open_now = 0;
      foreach (frag_bytes[i]) begin
        queue_word(CMD_LOAD, frag_bytes[i]);
        if (frag_bytes[i] == OP_OPEN) open_now++;
        else if (frag_bytes[i] == OP_CLOSE) open_now--;
        if (open_now > 0 && $urandom_range(0, 19) == 0)
          queue_word(CMD_STEP, 8'($urandom));
      end
      plan_len += frag_bytes.size();
      repeat (n_exec + $urandom_range(0, 2)) queue_word(CMD_STEP, 8'($urandom));
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
    wait_idle();

    // Run past the end, then an unmatched ']' sets the sticky error; a
    // matched pair and a plain byte follow, and every step reports the
    // bracket error
    repeat (40) queue_word(CMD_STEP, 8'($urandom));
    queue_word(CMD_LOAD, OP_CLOSE);
    queue_word(CMD_LOAD, OP_OPEN);
    queue_word(CMD_LOAD, OP_CLOSE);
    queue_word(CMD_LOAD, pick_plain(1'b1));
    repeat (6) queue_word(CMD_STEP, 8'($urandom));

    wait_idle();
    repeat (16) @(posedge clk);
    $display("%0d words taken (%0d steps), program length %0d, tape pointer %0d",
             words_taken, steps_taken, prog_len, tape_ptr);
    $display("results: %0d char, %0d dump, %0d halt, %0d bracket error",
             kind_seen[KIND_CHAR], kind_seen[KIND_DUMP], kind_seen[KIND_HALT],
             kind_seen[KIND_ERROR]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd8 * TIMEOUT_CYCLES);
    $display("simulation failed");
    $finish;
  end

endmodule
